// ===== rtl/swq_pkg.sv =====
// Package for the sliding window quota check unit.
// Ring geometry, config register indexes, verdict codes and shared types.
// No dependencies.
package swq_pkg;

	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int VERDICT_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_LIMIT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd1;

	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_OVER_QUOTA = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_RING_FULL  = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] amount;
		logic [DATA_W-1:0] stamp;
	} ring_entry_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [DATA_W-1:0]    total;
	} result_t;

endpackage

// ===== rtl/swq_ring_ram.sv =====
// Ring storage for admitted (amount, time) entries.
// One write port, one read port, registered read data. Uses swq_pkg.
module swq_ring_ram
	import swq_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [RING_AW-1:0] wr_addr,
	input  ring_entry_t        wr_data,
	input  logic [RING_AW-1:0] rd_addr,
	output ring_entry_t        rd_data
);

	ring_entry_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/swq_ctrl.sv =====
// Request sequencer: expires old ring entries one per cycle, then decides.
// Holds ring pointers and the running total. Uses swq_pkg and swq_ring_ram.
module swq_ctrl
	import swq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] request_amount,
	input  logic [DATA_W-1:0] now_seconds,
	input  logic [DATA_W-1:0] quota_limit,
	input  logic [DATA_W-1:0] window_seconds,
	input  logic              res_ready,
	output logic              res_valid,
	output result_t           res
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_CHECK = 1'b1;

	logic               state_q;
	logic [DATA_W-1:0]  amount_q;
	logic [DATA_W-1:0]  now_q;
	logic [RING_AW-1:0] oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  total_q;

	ring_entry_t        rd_data;
	ring_entry_t        wr_entry;
	logic [RING_AW-1:0] oldest_d;
	logic [RING_AW-1:0] oldest_inc;
	logic [RING_AW:0]   tail_sum;
	logic [RING_AW-1:0] tail_slot;
	logic [DATA_W-1:0]  head_age;
	logic [DATA_W:0]    sum33;
	logic               expire;
	logic               over;
	logic               full;
	logic               check;
	logic               pop;
	logic               decide;
	logic               admit;
	logic               accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign check    = (state_q == ST_CHECK);

	assign head_age = now_q - rd_data.stamp;
	assign expire   = (count_q != '0) && (head_age > window_seconds);
	assign sum33    = {1'b0, total_q} + {1'b0, amount_q};
	assign over     = sum33 > {1'b0, quota_limit};
	assign full     = (count_q == CNT_W'(RING_DEPTH));

	assign pop    = check && expire;
	assign decide = check && !expire && res_ready;
	assign admit  = decide && !over && !full;

	assign oldest_inc = (oldest_q == RING_AW'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign oldest_d   = pop ? oldest_inc : oldest_q;

	assign tail_sum  = (RING_AW + 1)'(oldest_q) + (RING_AW + 1)'(count_q);
	assign tail_slot = (tail_sum >= (RING_AW + 1)'(RING_DEPTH))
		? RING_AW'(tail_sum - (RING_AW + 1)'(RING_DEPTH))
		: RING_AW'(tail_sum);

	assign wr_entry.amount = amount_q;
	assign wr_entry.stamp  = now_q;

	swq_ring_ram u_ring (
		.clk     (clk),
		.wr_en   (admit),
		.wr_addr (tail_slot),
		.wr_data (wr_entry),
		.rd_addr (oldest_d),
		.rd_data (rd_data)
	);

	always_comb begin
		res_valid = decide;
		res.total = total_q;
		if (over) begin
			res.verdict = VERDICT_OVER_QUOTA;
		end else if (full) begin
			res.verdict = VERDICT_RING_FULL;
		end else begin
			res.verdict = VERDICT_ACCEPT;
			res.total   = sum33[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
		end else begin
			oldest_q <= oldest_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (pop) begin
						count_q <= count_q - 1'b1;
						total_q <= total_q - rd_data.amount;
					end else if (decide) begin
						state_q <= ST_IDLE;
						if (admit) begin
							count_q <= count_q + 1'b1;
							total_q <= sum33[DATA_W-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= request_amount;
			now_q    <= now_seconds;
		end
	end

endmodule

// ===== rtl/sliding_window_quota_check_unit.sv =====
// Sliding window quota check unit: top level with config registers and output register.
// The result is registered in the output register after the controller has expired old entries
// and decided; a stalled output holds the decision back.
// A new request is taken only once the previous one has been decided; expiry walks
// the ring memory one entry per cycle through its single read port.
// Reset: ring empty, total zero, quota_limit 0, window_seconds 1; ring memory not cleared.
// Uses swq_pkg and swq_ctrl.
module sliding_window_quota_check_unit
	import swq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DATA_W-1:0]    request_amount,
	input  logic [DATA_W-1:0]    now_seconds,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [VERDICT_W-1:0] verdict,
	output logic [DATA_W-1:0]    window_total
);

	logic [DATA_W-1:0] quota_q;
	logic [DATA_W-1:0] window_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              res_ready;
	logic              res_valid;
	result_t           res;

	assign res_ready = !out_valid_q || !out_stall;

	swq_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.request_amount (request_amount),
		.now_seconds    (now_seconds),
		.quota_limit    (quota_q),
		.window_seconds (window_q),
		.res_ready      (res_ready),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q  <= '0;
			window_q <= DATA_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_QUOTA_LIMIT:    quota_q  <= cfg_data;
				CFG_WINDOW_SECONDS: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = out_q.verdict;
	assign window_total = out_q.total;

endmodule
